// File: design/sidelink_channel_busy_ratio_monitor_defines.svh
// ---------------------------------------------------------------------------
// sidelink channel busy ratio monitor assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous reset
// ---------------------------------------------------------------------------
`ifndef SIDELINK_CHANNEL_BUSY_RATIO_MONITOR_DEFINES_SVH
`define SIDELINK_CHANNEL_BUSY_RATIO_MONITOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define SCBRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SCBRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/scbrm_pkg.sv
// ---------------------------------------------------------------------------
// scbrm_pkg
// shared sizes, types and helpers of the channel busy ratio monitor
// ---------------------------------------------------------------------------
`default_nettype none

package scbrm_pkg;

  // ring sizing
  localparam int WINDOW_DEPTH = 256;
  localparam int RING_AW      = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = $clog2(WINDOW_DEPTH * 255 + 1);

  // field widths
  localparam int TIME_W = 32;
  localparam int TX_W   = 16;
  localparam int LEN_W  = 8;
  localparam int PWR_W  = 11;
  localparam int BR_W   = 17;
  localparam int NC_W   = 9;

  // divider sizing: numerator is sum shifted up by 32, denominator is
  // slots (16) * fraction (17) * subchannels (8)
  localparam int NUM_W      = SUM_W + 32;
  localparam int P1_W       = 33;
  localparam int DEN_W      = 41;
  localparam int DIV_STEP_W = $clog2(NUM_W);

  // register indexes
  localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] REG_SLOTS      = 2'd1;
  localparam logic [1:0] REG_FRACTION   = 2'd2;
  localparam logic [1:0] REG_SUBCHANS   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [TX_W-1:0]   tx;
    logic [LEN_W-1:0]  len;
    logic [PWR_W-1:0]  power;
  } entry_t;

  typedef enum logic [4:0] {
    ST_WIPE, ST_IDLE,
    ST_P1_RD, ST_P1_CHK,
    ST_REC, ST_REC_RD, ST_REC_DROP, ST_REC_WR,
    ST_P2_RD, ST_P2_CHK,
    ST_SR_INIT, ST_SR_RD, ST_SR_CHK, ST_SR_SEEN,
    ST_CL_INIT, ST_CL_RD, ST_CL_WR,
    ST_DIV, ST_DIV_WAIT, ST_DONE
  } state_t;

  // busy ratio unit phases
  typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV} div_phase_t;

  typedef struct packed {
    logic load;
    logic rd_head;
    logic rd_walk;
    logic drop;
    logic ovf;
    logic write;
    logic idx_load;
    logic seen_rd;
    logic seen_set;
    logic seen_clr;
    logic wipe;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic expired;
    logic rx;
    logic idx_zero;
    logic wipe_last;
    logic div_done;
    logic out_free;
  } stat_t;

  // ring position a + b with wrap, a below depth, b at most depth
  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(WINDOW_DEPTH)) begin
      s = s - (CNT_W+1)'(WINDOW_DEPTH);
    end
    return s[RING_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/sidelink_channel_busy_ratio_monitor.sv
// ---------------------------------------------------------------------------
// sidelink_channel_busy_ratio_monitor
// sliding-window busy ratio, neighbour count and newest rsrp lookup
// ---------------------------------------------------------------------------
// One item at a time. The work for an item grows with P, the number of
// expired entries dropped, N, the live entries left (up to 256), and
// NUM_W = 48, the quotient bits of the busy ratio division: the
// newest-first walk visits each entry with a ring read, a bitmap read and
// a bitmap set on the single ring read port and seen-id bitmap, the bitmap
// clean walk with a ring read and a bitmap clear, and the divider gives one
// bit per cycle. After reset the seen-id bitmap is cleared one id per cycle,
// and no item is accepted during that pass; configuration writes are taken.
// The result register lets the next item start while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module sidelink_channel_busy_ratio_monitor import scbrm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input item
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now_time, sample_time, tx_id, sub_len, rsrp, query_id, zero pad
  input  wire logic [119:0] in_tdata,
  // rx_valid
  input  wire logic [0:0]   in_tuser,
  // result item
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // busy_ratio, neighbour_count, last_rsrp, zero pad
  output logic [39:0]       out_tdata,
  // rsrp_found, overflow
  output logic [1:0]        out_tuser,
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [23:0] win_r;
  logic [15:0] slots_r;
  logic [16:0] frac_r;
  logic [7:0]  nsub_r;

  cmd_t  cmd;
  stat_t stat;
  logic  idle;
  logic  accept;

  logic [BR_W-1:0]  o_busy;
  logic [NC_W-1:0]  o_ncnt;
  logic             o_found;
  logic [PWR_W-1:0] o_power;
  logic             o_ovf;

  // register file
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= 24'd100000;
      slots_r <= 16'd100;
      frac_r  <= 17'd65536;
      nsub_r  <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        REG_WINDOW_LEN: win_r   <= cfg_pwdata[23:0];
        REG_SLOTS:      slots_r <= cfg_pwdata[15:0];
        REG_FRACTION:   frac_r  <= cfg_pwdata[16:0];
        REG_SUBCHANS:   nsub_r  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WINDOW_LEN: cfg_prdata = {8'd0, win_r};
      REG_SLOTS:      cfg_prdata = {16'd0, slots_r};
      REG_FRACTION:   cfg_prdata = {15'd0, frac_r};
      REG_SUBCHANS:   cfg_prdata = {24'd0, nsub_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // input handshake
  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;

  scbrm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stat   (stat),
    .cmd    (cmd),
    .idle   (idle)
  );

  scbrm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_now    (in_tdata[31:0]),
    .in_rx     (in_tuser[0]),
    .in_sample (in_tdata[63:32]),
    .in_tx     (in_tdata[79:64]),
    .in_len    (in_tdata[87:80]),
    .in_power  (in_tdata[98:88]),
    .in_query  (in_tdata[114:99]),
    .win_len   (win_r),
    .slots     (slots_r),
    .frac      (frac_r),
    .nsub      (nsub_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_busy  (o_busy),
    .out_ncnt  (o_ncnt),
    .out_found (o_found),
    .out_power (o_power),
    .out_ovf   (o_ovf)
  );

  // result packing
  assign out_tdata = {3'd0, o_power, o_ncnt, o_busy};
  assign out_tuser = {o_ovf, o_found};

endmodule

`default_nettype wire

// File: design/scbrm_div.sv
// ---------------------------------------------------------------------------
// scbrm_div
// busy ratio unit: denominator product over two stages, then restoring
// division one quotient bit per cycle, saturated to Q1.16 one
// ---------------------------------------------------------------------------
`default_nettype none

module scbrm_div import scbrm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] sum,
  input  wire logic [15:0]      slots,
  input  wire logic [16:0]      frac,
  input  wire logic [7:0]       nsub,
  output logic                  done,
  output logic [BR_W-1:0]       quot
);

  div_phase_t            phase_r, phase_nxt;
  logic [DIV_STEP_W-1:0] step_r;
  logic [P1_W-1:0]       p1_r;
  logic [DEN_W-1:0]      den_r;
  logic [DEN_W-1:0]      rem_r;
  logic [NUM_W-1:0]      num_r;
  logic                  zero_r;
  logic                  done_r;
  logic [BR_W-1:0]       quot_r;

  logic [16:0]      frac_eff;
  logic [7:0]       nsub_eff;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [NUM_W-1:0] q_new;

  // out-of-range fraction counts as all slots, zero subchannels as one
  assign frac_eff = (frac == 17'd0 || frac > 17'd65536) ? 17'd65536 : frac;
  assign nsub_eff = (nsub == 8'd0) ? 8'd1 : nsub;

  // one restoring step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign q_new = {num_r[NUM_W-2:0], ge};

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (start) phase_nxt = PH_MUL;
      PH_MUL:  phase_nxt = PH_DIV;
      PH_DIV:  if (step_r == DIV_STEP_W'(NUM_W - 1)) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == PH_DIV) && (step_r == DIV_STEP_W'(NUM_W - 1));
    end
  end

  // operand and iteration registers
  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          p1_r   <= P1_W'(slots) * P1_W'(frac_eff);
          num_r  <= {sum, 32'd0};
          rem_r  <= '0;
          zero_r <= (slots == 16'd0);
        end
      end
      PH_MUL: begin
        den_r  <= DEN_W'(p1_r) * DEN_W'(nsub_eff);
        step_r <= '0;
      end
      PH_DIV: begin
        rem_r  <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        num_r  <= q_new;
        step_r <= step_r + 1'b1;
        if (step_r == DIV_STEP_W'(NUM_W - 1)) begin
          if (zero_r) begin
            quot_r <= '0;
          end else if (q_new > NUM_W'(65536)) begin
            quot_r <= BR_W'(65536);
          end else begin
            quot_r <= q_new[BR_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: design/scbrm_dp.sv
// ---------------------------------------------------------------------------
// scbrm_dp
// datapath: reception ring, seen-id bitmap, walk counters, busy ratio unit
// and the result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "sidelink_channel_busy_ratio_monitor_defines.svh"

module scbrm_dp import scbrm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  // captured on load
  input  wire logic [TIME_W-1:0] in_now,
  input  wire logic              in_rx,
  input  wire logic [TIME_W-1:0] in_sample,
  input  wire logic [TX_W-1:0]   in_tx,
  input  wire logic [LEN_W-1:0]  in_len,
  input  wire logic [PWR_W-1:0]  in_power,
  input  wire logic [TX_W-1:0]   in_query,
  // configuration
  input  wire logic [23:0]       win_len,
  input  wire logic [15:0]       slots,
  input  wire logic [16:0]       frac,
  input  wire logic [7:0]        nsub,
  // result register
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [BR_W-1:0]        out_busy,
  output logic [NC_W-1:0]        out_ncnt,
  output logic                   out_found,
  output logic [PWR_W-1:0]       out_power,
  output logic                   out_ovf
);

  // ring and bitmap storage
  entry_t ring_mem [WINDOW_DEPTH];
  logic   seen_mem [2**TX_W];

  entry_t rd_q;
  logic   seen_q;

  // ring state
  logic [RING_AW-1:0] head_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   idx_r;
  logic [TX_W-1:0]    wipe_r;

  // captured item
  logic [TIME_W-1:0] cutoff_r;
  logic              rx_r;
  logic [TIME_W-1:0] sample_r;
  logic [TX_W-1:0]   tx_r;
  logic [LEN_W-1:0]  len_r;
  logic [PWR_W-1:0]  power_r;
  logic [TX_W-1:0]   query_r;

  // working results
  logic             w_found_r;
  logic [PWR_W-1:0] w_power_r;
  logic [CNT_W-1:0] w_ncnt_r;
  logic             w_ovf_r;

  logic             out_valid_r;
  logic [BR_W-1:0]  out_busy_r;
  logic [NC_W-1:0]  out_ncnt_r;
  logic             out_found_r;
  logic [PWR_W-1:0] out_power_r;
  logic             out_ovf_r;

  logic [RING_AW-1:0] rd_addr;
  logic [RING_AW-1:0] wr_addr;
  logic [CNT_W-1:0]   idx_m1;
  logic               div_done;
  logic [BR_W-1:0]    div_quot;

  assign idx_m1  = idx_r - 1'b1;
  assign rd_addr = cmd.rd_walk ? ring_add(head_r, idx_m1) : head_r;
  assign wr_addr = ring_add(head_r, count_r);

  // ring port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ring_mem[wr_addr] <= '{stamp: sample_r, tx: tx_r, len: len_r, power: power_r};
    end
    if (cmd.rd_head || cmd.rd_walk) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  // seen bitmap port
  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      seen_mem[wipe_r] <= 1'b0;
    end else if (cmd.seen_clr) begin
      seen_mem[rd_q.tx] <= 1'b0;
    end else if (cmd.seen_set && !seen_q) begin
      seen_mem[rd_q.tx] <= 1'b1;
    end
    if (cmd.seen_rd) begin
      seen_q <= seen_mem[rd_q.tx];
    end
  end

  // capture of the item, cutoff clamped at zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cutoff_r <= (in_now > TIME_W'(win_len)) ? in_now - TIME_W'(win_len) : '0;
      rx_r     <= in_rx;
      sample_r <= in_sample;
      tx_r     <= in_tx;
      len_r    <= (in_len == '0) ? LEN_W'(1) : in_len;
      power_r  <= in_power;
      query_r  <= in_query;
    end
  end

  // head, fill count, occupied sum and walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      wipe_r  <= '0;
    end else begin
      if (cmd.drop) begin
        head_r  <= ring_add(head_r, CNT_W'(1));
        count_r <= count_r - 1'b1;
        sum_r   <= sum_r - SUM_W'(rd_q.len);
      end else if (cmd.write) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUM_W'(len_r);
      end
      if (cmd.idx_load) begin
        idx_r <= count_r;
      end else if (cmd.seen_set || cmd.seen_clr) begin
        idx_r <= idx_m1;
      end
      if (cmd.wipe) begin
        wipe_r <= wipe_r + 1'b1;
      end
    end
  end

  // working results of the current item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_found_r <= 1'b0;
      w_power_r <= '0;
      w_ncnt_r  <= '0;
      w_ovf_r   <= 1'b0;
    end else begin
      if (cmd.ovf) begin
        w_ovf_r <= 1'b1;
      end
      // newest first, so the first match wins
      if (cmd.seen_rd && !w_found_r && rd_q.tx == query_r) begin
        w_found_r <= 1'b1;
        w_power_r <= rd_q.power;
      end
      if (cmd.seen_set && !seen_q) begin
        w_ncnt_r <= w_ncnt_r + 1'b1;
      end
    end
  end

  scbrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .sum   (sum_r),
    .slots (slots),
    .frac  (frac),
    .nsub  (nsub),
    .done  (div_done),
    .quot  (div_quot)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_busy_r  <= div_quot;
      out_ncnt_r  <= NC_W'(w_ncnt_r);
      out_found_r <= w_found_r;
      out_power_r <= w_power_r;
      out_ovf_r   <= w_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_busy  = out_busy_r;
  assign out_ncnt  = out_ncnt_r;
  assign out_found = out_found_r;
  assign out_power = out_power_r;
  assign out_ovf   = out_ovf_r;

  // status to the controller
  assign stat.count_zero = (count_r == '0);
  assign stat.full       = (count_r == CNT_W'(WINDOW_DEPTH));
  assign stat.expired    = (rd_q.stamp < cutoff_r);
  assign stat.rx         = rx_r;
  assign stat.idx_zero   = (idx_r == '0);
  assign stat.wipe_last  = (wipe_r == '1);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_ready;

  // checks
  `SCBRM_ASSERT(a_count_max, count_r <= CNT_W'(WINDOW_DEPTH), "ring fill count above depth")
  `SCBRM_ASSERT_IMP(a_drop_nonempty, cmd.drop, count_r != '0, "drop from an empty ring")
  `SCBRM_ASSERT_IMP(a_write_room, cmd.write, count_r < CNT_W'(WINDOW_DEPTH), "write to full ring")
  `SCBRM_ASSERT_IMP(a_walk_range, cmd.rd_walk, idx_r != '0 && idx_r <= count_r,
                    "walk index outside live entries")

endmodule

`default_nettype wire

// File: design/scbrm_ctrl.sv
// ---------------------------------------------------------------------------
// scbrm_ctrl
// sequencer: post-reset bitmap wipe, then per item prune, record, prune,
// newest-first walk, bitmap clean walk, busy ratio division, result hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module scbrm_ctrl import scbrm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       idle
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_WIPE:     if (stat.wipe_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (accept) state_nxt = ST_P1_RD;
      ST_P1_RD:    state_nxt = stat.count_zero ? ST_REC : ST_P1_CHK;
      ST_P1_CHK:   state_nxt = stat.expired ? ST_P1_RD : ST_REC;
      ST_REC: begin
        if (!stat.rx) begin
          state_nxt = ST_P2_RD;
        end else if (stat.full) begin
          state_nxt = ST_REC_RD;
        end else begin
          state_nxt = ST_REC_WR;
        end
      end
      ST_REC_RD:   state_nxt = ST_REC_DROP;
      ST_REC_DROP: state_nxt = ST_REC_WR;
      ST_REC_WR:   state_nxt = ST_P2_RD;
      ST_P2_RD:    state_nxt = stat.count_zero ? ST_SR_INIT : ST_P2_CHK;
      ST_P2_CHK:   state_nxt = stat.expired ? ST_P2_RD : ST_SR_INIT;
      ST_SR_INIT:  state_nxt = ST_SR_RD;
      ST_SR_RD:    state_nxt = stat.idx_zero ? ST_CL_INIT : ST_SR_CHK;
      ST_SR_CHK:   state_nxt = ST_SR_SEEN;
      ST_SR_SEEN:  state_nxt = ST_SR_RD;
      ST_CL_INIT:  state_nxt = ST_CL_RD;
      ST_CL_RD:    state_nxt = stat.idx_zero ? ST_DIV : ST_CL_WR;
      ST_CL_WR:    state_nxt = ST_CL_RD;
      ST_DIV:      state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (stat.div_done) state_nxt = ST_DONE;
      ST_DONE:     if (stat.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      ST_WIPE:     cmd.wipe = 1'b1;
      ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = accept;
      end
      ST_P1_RD, ST_P2_RD: cmd.rd_head = !stat.count_zero;
      ST_P1_CHK, ST_P2_CHK: cmd.drop = stat.expired;
      ST_REC:      cmd = '0;
      ST_REC_RD:   cmd.rd_head = 1'b1;
      ST_REC_DROP: begin
        cmd.drop = 1'b1;
        cmd.ovf  = 1'b1;
      end
      ST_REC_WR:   cmd.write = 1'b1;
      ST_SR_INIT, ST_CL_INIT: cmd.idx_load = 1'b1;
      ST_SR_RD, ST_CL_RD: cmd.rd_walk = !stat.idx_zero;
      ST_SR_CHK:   cmd.seen_rd = 1'b1;
      ST_SR_SEEN:  cmd.seen_set = 1'b1;
      ST_CL_WR:    cmd.seen_clr = 1'b1;
      ST_DIV:      cmd.div_start = 1'b1;
      ST_DIV_WAIT: cmd = '0;
      ST_DONE:     cmd.out_load = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire
